@@ rtl/bole_pkg.sv @@
`default_nettype none

package bole_pkg;

    // Request codes carried in the func field.
    localparam logic [2:0] FN_APPEND  = 3'd0;
    localparam logic [2:0] FN_INSERT  = 3'd1;
    localparam logic [2:0] FN_REMOVE  = 3'd2;
    localparam logic [2:0] FN_REPLACE = 3'd3;
    localparam logic [2:0] FN_FIND    = 3'd4;

    // Result status codes.
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_FULL      = 2'd1;
    localparam logic [1:0] STS_EMPTY     = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    // One request item.
    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] item_value;
        logic signed [31:0] new_value;
    } request_t;

    // One result item.
    typedef struct packed {
        logic [1:0] status;
        logic [4:0] position;
        logic [4:0] count;
    } result_t;

    // Update applied by every cell in the same cycle.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_APPEND,
        OP_INSERT,
        OP_REMOVE,
        OP_REPLACE
    } cell_op_t;

    // Control broadcast from the sequencer to the row of cells.
    typedef struct packed {
        logic     cmp_en;
        cell_op_t op;
    } cell_cmd_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC
    } state_t;

endpackage

`default_nettype wire

@@ rtl/bounded_ordered_list_engine.sv @@
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit entries held in a row of cells.
// Requests arrive on req (valid/ready) and each one produces exactly one
// result on rsp (valid/ready): a status, the 1-based matched or appended
// position, and the entry count after the request.
// Timing: an accepted request is compared in every cell in the compare pass
// (S_MATCH), and the list update and the registered result happen in the
// shift/write pass (S_EXEC) that follows it. A new request is taken in the
// same cycle the previous one completes, so the block works on one request
// at a time; the shift/write pass holds while a result waits in the output
// register.
// The first-match search ripples a single flag down the row of cells.
// Reset empties the list (count zero) and drops any pending result; the
// entry storage itself is not cleared, since only entries below the count
// are ever read.
// If the receiver holds rsp_ready low, the finished result stays in the
// output register; one further request can be accepted and compared, and it
// completes as soon as the output register frees up.
module bounded_ordered_list_engine #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire bole_pkg::request_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output bole_pkg::result_t       rsp
);
    import bole_pkg::*;

    localparam int unsigned   CW      = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    result_t       rsp_reg;
    result_t       rsp_next;
    request_t      req_reg;

    cell_cmd_t     cmd;
    logic [31:0]   wr_value;
    logic [31:0]   cell_value [DEPTH];
    logic          match_seen [DEPTH+1];
    logic [DEPTH-1:0] first_vec;
    logic [CW-1:0] match_pos;
    logic          found;
    logic          rsp_free;
    logic [1:0]    res_status;
    logic [CW-1:0] res_pos;
    logic [CW+4:0] pos_ext;
    logic [CW+4:0] cnt_ext;

    // Row of cells, each linked to its neighbors.
    assign match_seen[0] = 1'b0;
    assign wr_value  = (req_reg.func == FN_APPEND) ? req_reg.item_value : req_reg.new_value;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [31:0] left_v;
        logic [31:0] right_v;

        if (i == 0)
        begin : g_head
            assign left_v = cell_value[i];
        end
        else
        begin : g_body
            assign left_v = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_v = cell_value[i];
        end
        else
        begin : g_mid
            assign right_v = cell_value[i+1];
        end

        bole_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .count       (count_reg),
            .cmp_value   (req_reg.item_value),
            .wr_value    (wr_value),
            .left_value  (left_v),
            .right_value (right_v),
            .before_in   (match_seen[i]),
            .before_out  (match_seen[i+1]),
            .first       (first_vec[i]),
            .value       (cell_value[i])
        );
    end

    assign found = match_seen[DEPTH];

    // Encode the position of the single first-match cell.
    always_comb
    begin
        match_pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first_vec[i])
            begin
                match_pos = match_pos | CW'(i + 1);
            end
        end
    end

    assign rsp_free = !rsp_valid_reg || rsp_ready;

    // Sequencer: accept, compare, then update and report.
    always_comb
    begin
        state_next     = state_reg;
        req_ready      = 1'b0;
        cmd.cmp_en     = 1'b0;
        cmd.op         = OP_NONE;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        res_status     = STS_OK;
        res_pos        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                cmd.cmp_en = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (rsp_free)
                begin
                    unique case (req_reg.func) inside
                        FN_APPEND:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                res_status = STS_FULL;
                            end
                            else
                            begin
                                cmd.op     = OP_APPEND;
                                count_next = count_reg + CW'(1);
                                res_pos    = count_next;
                            end
                        end
                        FN_INSERT:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                res_status = STS_FULL;
                            end
                            else if (!found)
                            begin
                                res_status = STS_NOT_FOUND;
                            end
                            else
                            begin
                                cmd.op     = OP_INSERT;
                                count_next = count_reg + CW'(1);
                                res_pos    = match_pos;
                            end
                        end
                        FN_REMOVE, FN_REPLACE, FN_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = STS_EMPTY;
                            end
                            else if (!found)
                            begin
                                res_status = STS_NOT_FOUND;
                            end
                            else
                            begin
                                res_pos = match_pos;
                                if (req_reg.func == FN_REMOVE)
                                begin
                                    cmd.op     = OP_REMOVE;
                                    count_next = count_reg - CW'(1);
                                end
                                else if (req_reg.func == FN_REPLACE)
                                begin
                                    cmd.op = OP_REPLACE;
                                end
                            end
                        end
                        default:
                        begin
                            res_status = STS_OK;
                        end
                    endcase

                    rsp_valid_next   = 1'b1;
                    rsp_next.status  = res_status;
                    rsp_next.position = pos_ext[4:0];
                    rsp_next.count   = cnt_ext[4:0];
                    req_ready        = 1'b1;
                    state_next       = req_valid ? S_MATCH : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Fit position and count into the 5-bit result fields.
    assign pos_ext = {5'd0, res_pos};
    assign cnt_ext = {5'd0, count_next};

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The count never exceeds the list capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above capacity");

    // At most one cell claims the first match.
    a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> $onehot0(first_vec))
        else $error("several cells claim the first match");

    // The compare pass is always followed by the update pass.
    a_match_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MATCH) |=> (state_reg == S_EXEC))
        else $error("compare pass not followed by update");

    // The count moves only while a request completes.
    a_count_exec_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> $stable(count_reg))
        else $error("count changed outside the update pass");

    // An accepted request always enters the compare pass next.
    a_accept_to_match: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_MATCH))
        else $error("accepted request did not start a compare");

endmodule

`default_nettype wire

@@ rtl/bole_cell.sv @@
`default_nettype none

module bole_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned CW  = 5
) (
    input  wire logic              clk,
    input  wire bole_pkg::cell_cmd_t cmd,
    input  wire logic [CW-1:0]     count,
    input  wire logic [31:0]       cmp_value,
    input  wire logic [31:0]       wr_value,
    input  wire logic [31:0]       left_value,
    input  wire logic [31:0]       right_value,
    input  wire logic              before_in,
    output logic                   before_out,
    output logic                   first,
    output logic [31:0]            value
);
    import bole_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [31:0] value_reg;
    logic [31:0] value_next;
    logic        match_reg;
    logic        match_next;

    // Compare against the searched value; only entries inside the list count.
    always_comb
    begin
        match_next = match_reg;
        if (cmd.cmp_en)
        begin
            match_next = (value_reg == cmp_value) && (IDX_C < count);
        end
    end

    // A match somewhere ahead of this cell marks the whole tail of the row.
    assign first      = match_reg & ~before_in;
    assign before_out = before_in | match_reg;
    assign value      = value_reg;

    // Entry update: write, take from the left neighbor, or take from the right.
    always_comb
    begin
        value_next = value_reg;
        case (cmd.op)
            OP_APPEND:
            begin
                if (IDX_C == count)
                begin
                    value_next = wr_value;
                end
            end
            OP_INSERT:
            begin
                if (first)
                begin
                    value_next = wr_value;
                end
                else if (before_in)
                begin
                    value_next = left_value;
                end
            end
            OP_REMOVE:
            begin
                if (before_out)
                begin
                    value_next = right_value;
                end
            end
            OP_REPLACE:
            begin
                if (first)
                begin
                    value_next = wr_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        match_reg <= match_next;
    end

endmodule

`default_nettype wire

@@ verif/tb_bounded_ordered_list_engine.sv @@
`timescale 1ns / 100ps

module tb_bounded_ordered_list_engine;

    import bole_pkg::*;

    localparam int unsigned LIST_DEPTH  = 16;
    localparam int unsigned BLOCK_ITEMS = 25;
    localparam int unsigned RANDOM_ITEMS = 1420;
    localparam int unsigned STUCK_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES = 20;

    // Codes 5 to 7 of func carry no request and must leave the list alone.
    localparam logic [2:0] FN_FIRST_UNUSED = 3'd5;

    typedef enum {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } op_mix_t;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    request_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    result_t  rsp;

    // Local copy of the list that the block should be holding.
    logic signed [31:0] list_mem [LIST_DEPTH];
    int unsigned        list_len;

    result_t     awaited_results [$];
    int unsigned mismatch_count;
    int unsigned send_gap_max;
    int unsigned recv_gap_max;
    int unsigned stuck_cycles = 0;

    bounded_ordered_list_engine #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Applies one request to the local list and returns the result it must produce.
    function automatic result_t apply_to_list(input request_t r);
        result_t     res;
        int          hit;
        int unsigned i;
        int unsigned j;
        res.status = STS_OK;
        res.position = '0;
        hit = -1;
        for (i = 0; i < list_len; i++)
        begin
            if (hit < 0 && list_mem[i] == r.item_value)
                hit = i;
        end
        case (r.func)
            FN_APPEND:
            begin
                if (list_len >= LIST_DEPTH)
                    res.status = STS_FULL;
                else
                begin
                    list_mem[list_len] = r.item_value;
                    list_len++;
                    res.position = 5'(list_len);
                end
            end
            FN_INSERT:
            begin
                // A full list reports full before any search is made.
                if (list_len >= LIST_DEPTH)
                    res.status = STS_FULL;
                else if (hit < 0)
                    res.status = STS_NOT_FOUND;
                else
                begin
                    for (j = list_len; j > hit; j--)
                        list_mem[j] = list_mem[j - 1];
                    list_mem[hit] = r.new_value;
                    list_len++;
                    res.position = 5'(hit + 1);
                end
            end
            FN_REMOVE, FN_REPLACE, FN_FIND:
            begin
                if (list_len == 0)
                    res.status = STS_EMPTY;
                else if (hit < 0)
                    res.status = STS_NOT_FOUND;
                else
                begin
                    if (r.func == FN_REMOVE)
                    begin
                        for (j = hit; j + 1 < list_len; j++)
                            list_mem[j] = list_mem[j + 1];
                        list_len--;
                    end
                    else if (r.func == FN_REPLACE)
                        list_mem[hit] = r.new_value;
                    res.position = 5'(hit + 1);
                end
            end
            default:
            begin
            end
        endcase
        res.count = 5'(list_len);
        return res;
    endfunction

    // Small values give many duplicates; full-width values and extremes exercise every bit.
    function automatic logic signed [31:0] pick_fresh_value();
        int unsigned        roll;
        logic signed [31:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            v = 32'sh8000_0000;
        else if (roll < 6)
            v = 32'sh7fff_ffff;
        else if (roll < 50)
        begin
            v = $urandom_range(0, 8);
            v = v - 32'sd4;
        end
        else
            v = $urandom();
        return v;
    endfunction

    // Mostly a value the list already holds, so that searches tend to hit.
    function automatic logic signed [31:0] pick_search_value();
        if (list_len != 0 && $urandom_range(0, 99) < 70)
            return list_mem[$urandom_range(0, list_len - 1)];
        return pick_fresh_value();
    endfunction

    function automatic logic [2:0] pick_func(input op_mix_t mix);
        int unsigned roll;
        logic [2:0]  offset;
        roll = $urandom_range(0, 99);
        offset = 3'($urandom_range(0, 2));
        if (roll < 4)
            return FN_FIRST_UNUSED + offset;
        case (mix)
            MIX_GROW:
            begin
                if (roll < 40) return FN_APPEND;
                if (roll < 65) return FN_INSERT;
                if (roll < 75) return FN_REMOVE;
                if (roll < 85) return FN_REPLACE;
                return FN_FIND;
            end
            MIX_SHRINK:
            begin
                if (roll < 14) return FN_APPEND;
                if (roll < 24) return FN_INSERT;
                if (roll < 70) return FN_REMOVE;
                if (roll < 80) return FN_REPLACE;
                return FN_FIND;
            end
            default:
            begin
                if (roll < 25) return FN_APPEND;
                if (roll < 42) return FN_INSERT;
                if (roll < 62) return FN_REMOVE;
                if (roll < 78) return FN_REPLACE;
                return FN_FIND;
            end
        endcase
    endfunction

    // Either side runs without gaps, with short gaps, or with the longest ones.
    function automatic int unsigned pick_gap_limit();
        int unsigned roll;
        roll = $urandom_range(0, 3);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return 3;
        return 12;
    endfunction

    // Sends one item; valid stays high afterwards so the next item can follow at once.
    task automatic send_request(input logic [2:0] func, input logic signed [31:0] key,
                                input logic signed [31:0] repl);
        request_t    r;
        int unsigned gap;
        r.func = func;
        r.item_value = key;
        r.new_value = repl;
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        awaited_results.push_back(apply_to_list(r));
    endtask

    // Drops valid and waits until every outstanding result has come back.
    task automatic hold_until_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Every search request on a list with nothing in it.
    task automatic test_empty_list();
        send_request(FN_REMOVE, 32'sd0, 32'sd0);
        send_request(FN_REPLACE, 32'sh8000_0000, 32'sh7fff_ffff);
        send_request(FN_FIND, 32'sh7fff_ffff, 32'sd0);
        send_request(FN_INSERT, -32'sd1, 32'sd5);
    endtask

    // Fills the list with extreme and repeated values, then pushes past the top.
    task automatic test_fill_to_full();
        logic signed [31:0] fill_value;
        int unsigned        i;
        for (i = 0; i < LIST_DEPTH; i++)
        begin
            case (i)
                0: fill_value = 32'sh8000_0000;
                1: fill_value = 32'sh7fff_ffff;
                2: fill_value = 32'sd0;
                3: fill_value = -32'sd1;
                4: fill_value = 32'sh5555_5555;
                5: fill_value = 32'shaaaa_aaaa;
                default: fill_value = i - 6;
            endcase
            send_request(FN_APPEND, fill_value, 32'sd0);
        end
        send_request(FN_APPEND, 32'sd99, 32'sd0);
        // The value is absent, but a full list must still report full.
        send_request(FN_INSERT, 32'sh0bad_f00d, 32'sd1);
    endtask

    // First-match behavior of find, replace, remove and insert, plus an unused code.
    task automatic test_match_ops();
        send_request(FN_FIND, 32'sd0, 32'sd0);
        send_request(FN_REPLACE, 32'sd0, 32'sh1234_5678);
        send_request(FN_REMOVE, 32'sd0, 32'sd0);
        send_request(FN_INSERT, 32'sh0bad_f00d, 32'sd7);
        send_request(FN_INSERT, 32'sh7fff_ffff, 32'sh8000_0000);
        send_request(FN_FIRST_UNUSED + 3'd1, 32'sh7fff_ffff, 32'sd3);
    endtask

    // Blocks of random requests, each with its own mix of operations and pacing.
    task automatic test_random_traffic(input int unsigned n_items);
        op_mix_t     mix;
        int unsigned k;
        logic [2:0]  func;
        mix = MIX_EVEN;
        for (k = 0; k < n_items; k++)
        begin
            if (k % BLOCK_ITEMS == 0)
            begin
                // Now and then the sender waits for the block to go quiet.
                if (k / BLOCK_ITEMS == 8 || $urandom_range(0, 9) == 0)
                    hold_until_drained();
                case ($urandom_range(0, 2))
                    0: mix = MIX_GROW;
                    1: mix = MIX_SHRINK;
                    default: mix = MIX_EVEN;
                endcase
                send_gap_max = pick_gap_limit();
                recv_gap_max = pick_gap_limit();
            end
            func = pick_func(mix);
            send_request(func, pick_search_value(), pick_fresh_value());
        end
    endtask

    // Result side: random stalls before each item, then a field-by-field check.
    initial
    begin
        int unsigned stall;
        result_t     want;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, recv_gap_max);
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            if (awaited_results.size() == 0)
            begin
                $error("result with no request outstanding: status %0d position %0d count %0d",
                       rsp.status, rsp.position, rsp.count);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    mismatch_count++;
                end
                if (rsp.position !== want.position)
                begin
                    $error("position: expected %0d, got %0d", want.position, rsp.position);
                    mismatch_count++;
                end
                if (rsp.count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, rsp.count);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run if neither side moves an item for too long.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stuck_cycles = 0;
        else
            stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        list_len = 0;
        mismatch_count = 0;
        send_gap_max = 12;
        recv_gap_max = 12;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_fill_to_full();
        test_match_ops();
        test_random_traffic(RANDOM_ITEMS);

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
